[hw/rtl/cfbl_pkg.sv]
// shared types, sizes and helpers of the chained free block list allocator
`default_nettype none
package cfbl_pkg;

  localparam int LIST_LEN   = 16;
  localparam int NUM_BLOCKS = 1024;
  localparam int ID_W       = 10;
  localparam int CNT_W      = 11;
  localparam int SLOT_W     = $clog2(LIST_LEN);
  localparam int ROW_AW     = $clog2(NUM_BLOCKS);
  localparam int ROW_W      = LIST_LEN * ID_W;
  localparam int COUNT_MAX  = (NUM_BLOCKS < 2047) ? NUM_BLOCKS : 2047;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ROW_AW-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_LOAD,
    ST_DONE
  } state_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // spill row of a block; block count is a power of two, so the wrap is a mask
  function automatic row_t row_of(id_t id);
    logic [ROW_AW+ID_W-1:0] wide;
    wide = {{ROW_AW{1'b0}}, id};
    return wide[ROW_AW-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cfbl_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module cfbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/chained_free_block_list_allocator_top.sv]
// chained free block list allocator: head list registers, spill row ram, sequencer
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid, in_stall  | req_type, block_id
//   out     | out_valid, out_stall| status, granted_id, free_count
//
// a request steps through accept, slot search, update and result; an allocate that
// reloads the head list adds a load step for the registered spill ram read
// the free counter update is done by one shared saturating add/sub unit
// reset clears the head list, the free count and out_valid; the spill ram is
// not cleared, its rows are written before they are ever read
// a waiting result sits in the output register while the next request runs;
// only a second finished result waits on out_stall
`default_nettype none
module chained_free_block_list_allocator_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire logic           req_type,
  input  wire cfbl_pkg::id_t  block_id,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic           status,
  output      cfbl_pkg::id_t  granted_id,
  output      cfbl_pkg::cnt_t free_count
);

  import cfbl_pkg::*;

  state_t state, state_next;
  req_t   req;
  id_t    id;
  slot_t  slot, slot_next;
  logic   found, found_next;
  id_t    head      [LIST_LEN];
  id_t    head_next [LIST_LEN];
  cnt_t   count, count_next;
  logic   res_status;
  id_t    res_granted;

  logic             ram_we, ram_re;
  row_t             ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic is_alloc, is_free;
  logic cnt_inc, cnt_dec;
  logic done_load;
  logic reload;
  cnt_t cnt_sum;

  assign is_alloc = (req == REQ_ALLOC);
  assign is_free  = (req == REQ_FREE) && (id != '0);
  assign reload   = is_alloc && !found && (head[0] != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_FIND;
      ST_FIND: state_next = ST_EXEC;
      ST_EXEC: state_next = reload ? ST_LOAD : ST_DONE;
      ST_LOAD: state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    done_load = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_FIND: ;
      ST_EXEC: begin
        ram_re  = reload;
        ram_we  = is_free && !found;
        cnt_inc = is_free;
        cnt_dec = is_alloc && found;
      end
      ST_LOAD: cnt_dec = 1'b1;
      ST_DONE: done_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // slot search: highest used entry for allocate, lowest empty one for free
  always_comb begin
    slot_next  = '0;
    found_next = 1'b0;
    if (is_alloc) begin
      for (int j = 1; j < LIST_LEN; j++) begin
        if (head[j] != '0) begin
          slot_next  = slot_t'(j);
          found_next = 1'b1;
        end
      end
    end else begin
      for (int j = LIST_LEN - 1; j >= 1; j--) begin
        if (head[j] == '0) begin
          slot_next  = slot_t'(j);
          found_next = 1'b1;
        end
      end
    end
  end

  // shared saturating counter unit
  assign cnt_sum = cnt_inc ? (count + cnt_t'(1)) : (count - cnt_t'(1));

  always_comb begin
    count_next = count;
    if ((cnt_inc && (count < cnt_t'(COUNT_MAX))) || (cnt_dec && (count != '0))) begin
      count_next = cnt_sum;
    end
  end

  // head list update
  always_comb begin
    for (int j = 0; j < LIST_LEN; j++) begin
      head_next[j] = head[j];
    end
    if (state == ST_EXEC) begin
      if (is_alloc && found) begin
        head_next[slot] = '0;
      end else if (is_free && found) begin
        head_next[slot] = id;
      end else if (is_free) begin
        // full head: it moves into the freed block, which becomes the link
        for (int j = 1; j < LIST_LEN; j++) begin
          head_next[j] = '0;
        end
        head_next[0] = id;
      end
    end else if (state == ST_LOAD) begin
      for (int j = 0; j < LIST_LEN; j++) begin
        head_next[j] = ram_rdata[j*ID_W +: ID_W];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LIST_LEN; j++) begin
      ram_wdata[j*ID_W +: ID_W] = head[j];
    end
  end

  assign ram_waddr = row_of(id);
  assign ram_raddr = row_of(head[0]);

  cfbl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BLOCKS)
  ) u_spill (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < LIST_LEN; j++) begin
        head[j] <= '0;
      end
    end else begin
      state <= state_next;
      count <= count_next;
      for (int j = 0; j < LIST_LEN; j++) begin
        head[j] <= head_next[j];
      end
      if (done_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req <= req_t'(req_type);
      id  <= block_id;
    end
    if (state == ST_FIND) begin
      slot  <= slot_next;
      found <= found_next;
    end
    if (state == ST_EXEC) begin
      res_status  <= (is_alloc && !found && head[0] == '0) ? STATUS_EMPTY : STATUS_OK;
      res_granted <= is_alloc ? (found ? head[slot] : head[0]) : '0;
    end
    if (done_load) begin
      status     <= res_status;
      granted_id <= res_granted;
      free_count <= count;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_find: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_FIND))
    else $error("accepted transaction did not start the slot search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_count <= cnt_t'(COUNT_MAX)))
    else $error("free count above its bound");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_EMPTY) |-> (granted_id == '0))
    else $error("failed allocate granted a block");

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("spill ram read and written in one cycle");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> $past(ram_re))
    else $error("head reload without a spill row read");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the chained free block list allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfbl_pkg::*;

  typedef struct packed {
    logic st;
    id_t  gid;
    cnt_t cnt;
  } alloc_result_t;

  typedef struct packed {
    req_t          req;
    id_t           id;
    logic          typed;
    alloc_result_t res;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  id_t  block_id;
  logic out_valid;
  logic out_stall;
  logic status;
  id_t  granted_id;
  cnt_t free_count;

  // shadow of the allocator state
  id_t  head_slots [LIST_LEN];
  id_t  spill_rows [NUM_BLOCKS][LIST_LEN];
  cnt_t free_cnt;

  alloc_result_t pending_results [$];
  int  error_cnt;
  int  items_sent;
  bit  quiet;
  bit  hold_done;

  // typed rows hold results that follow directly from the request order
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{REQ_ALLOC, 10'd0,    1'b1, '{STATUS_EMPTY, 10'd0,    11'd0}},
    '{REQ_FREE,  10'd0,    1'b1, '{STATUS_OK,    10'd0,    11'd0}},
    '{REQ_FREE,  10'd1023, 1'b1, '{STATUS_OK,    10'd0,    11'd1}},
    '{REQ_ALLOC, 10'd0,    1'b1, '{STATUS_OK,    10'd1023, 11'd0}},
    '{REQ_ALLOC, 10'd0,    1'b1, '{STATUS_EMPTY, 10'd0,    11'd0}},
    '{REQ_FREE,  10'd1,    1'b0, '0},
    '{REQ_FREE,  10'd2,    1'b0, '0},
    '{REQ_FREE,  10'd4,    1'b0, '0},
    '{REQ_FREE,  10'd8,    1'b0, '0},
    '{REQ_FREE,  10'd16,   1'b0, '0},
    '{REQ_FREE,  10'd32,   1'b0, '0},
    '{REQ_FREE,  10'd64,   1'b0, '0},
    '{REQ_FREE,  10'd128,  1'b0, '0},
    '{REQ_FREE,  10'd256,  1'b0, '0},
    '{REQ_FREE,  10'd512,  1'b0, '0},
    '{REQ_FREE,  10'd682,  1'b0, '0},
    '{REQ_FREE,  10'd341,  1'b0, '0},
    '{REQ_FREE,  10'd3,    1'b0, '0},
    '{REQ_FREE,  10'd5,    1'b0, '0},
    '{REQ_FREE,  10'd1022, 1'b0, '0},
    // head full: this one spills the list into its own row
    '{REQ_FREE,  10'd700,  1'b0, '0},
    // follows the link and reloads the head
    '{REQ_ALLOC, 10'd0,    1'b0, '0},
    '{REQ_ALLOC, 10'd0,    1'b0, '0},
    // double free goes undetected
    '{REQ_FREE,  10'd3,    1'b0, '0},
    '{REQ_ALLOC, 10'd0,    1'b0, '0}
  };

  chained_free_block_list_allocator_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .block_id   (block_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .granted_id (granted_id),
    .free_count (free_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic alloc_result_t apply_request(req_t req, id_t id);
    alloc_result_t r;
    int slot;
    r = '0;
    r.st = STATUS_OK;
    slot = -1;
    if (req == REQ_ALLOC) begin
      for (int j = LIST_LEN - 1; j >= 1 && slot < 0; j--) begin
        if (head_slots[j] != '0) slot = j;
      end
      if (slot >= 1) begin
        r.gid = head_slots[slot];
        head_slots[slot] = '0;
      end else if (head_slots[0] != '0) begin
        r.gid = head_slots[0];
        for (int j = 0; j < LIST_LEN; j++) head_slots[j] = spill_rows[r.gid][j];
      end else begin
        r.st = STATUS_EMPTY;
      end
      if (r.st == STATUS_OK) begin
        if (free_cnt > 0) free_cnt--;
      end
    end else if (id != '0) begin
      for (int j = 1; j < LIST_LEN && slot < 0; j++) begin
        if (head_slots[j] == '0) slot = j;
      end
      if (slot >= 1) begin
        head_slots[slot] = id;
      end else begin
        for (int j = 0; j < LIST_LEN; j++) begin
          spill_rows[id][j] = head_slots[j];
          head_slots[j] = '0;
        end
        head_slots[0] = id;
      end
      if (free_cnt < COUNT_MAX) free_cnt++;
    end
    r.cnt = free_cnt;
    return r;
  endfunction

  // offer one request, hold it until accepted, then record its expected result
  task automatic send_request(req_t req, id_t id, logic typed, alloc_result_t typed_res);
    alloc_result_t predicted;
    bit accepted;
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    block_id <= id;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      accepted = in_valid && !in_stall;
    end
    predicted = apply_request(req, id);
    pending_results.push_back(typed ? typed_res : predicted);
    if (req == REQ_ALLOC || id != '0) items_sent++;
  endtask

  function automatic id_t pick_id();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return id_t'(1023);
      2: return id_t'(1);
      default: return id_t'($urandom_range(1, 1023));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status got %0d expected %0d", status, want.st));
        if (granted_id !== want.gid)
          report_mismatch($sformatf("granted_id got %0d expected %0d", granted_id, want.gid));
        if (free_count !== want.cnt)
          report_mismatch($sformatf("free_count got %0d expected %0d", free_count, want.cnt));
      end
    end
  end

  // receiver side: random stall bursts and one long hold-off
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= 60) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int burst_len;
    int fill_cnt;
    int mixed_cnt;
    req_t burst_req;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = 1'b0;
    block_id = '0;
    error_cnt = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_done = 1'b0;
    free_cnt = '0;
    for (int j = 0; j < LIST_LEN; j++) head_slots[j] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].id, directed_rows[i].typed,
                   directed_rows[i].res);
    end

    // mixed bursts of frees and allocates so the list spills and reloads
    mixed_cnt = 0;
    while (mixed_cnt < 200) begin
      burst_req = ($urandom_range(0, 99) < 55) ? REQ_FREE : REQ_ALLOC;
      burst_len = $urandom_range(1, 20);
      repeat (burst_len) begin
        send_request(burst_req, burst_req == REQ_FREE ? pick_id() : id_t'($urandom),
                     1'b0, '0);
        mixed_cnt++;
      end
    end

    // fill up to the counter ceiling and keep freeing there for a while
    fill_cnt = 0;
    while (fill_cnt < 40) begin
      send_request(REQ_FREE, pick_id(), 1'b0, '0);
      if (free_cnt == cnt_t'(COUNT_MAX)) fill_cnt++;
    end

    // allocate back down, the tail runs without idling
    for (int i = 0; i < 330; i++) begin
      if (i >= 180) quiet = 1'b1;
      send_request(REQ_ALLOC, id_t'($urandom), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (error_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
